// ----- rtl/tcp_session_tracking_table_unit_defines.svh -----
// Assertion macros shared by the RTL.
`ifndef TCP_SESSION_TRACKING_TABLE_UNIT_DEFINES_SVH
`define TCP_SESSION_TRACKING_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define TSTT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TSTT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/tstt_pkg.sv -----
package tstt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;

   localparam logic [2:0] ACT_UPDATED = 3'd0;
   localparam logic [2:0] ACT_CREATED = 3'd1;
   localparam logic [2:0] ACT_REMOVED = 3'd2;
   localparam logic [2:0] ACT_IGNORED = 3'd3;
   localparam logic [2:0] ACT_DROPPED = 3'd4;

   localparam logic [1:0] OP_NONE   = 2'd0;
   localparam logic [1:0] OP_UPDATE = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_CREATE = 2'd3;

   typedef struct packed {
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] seq_number;
      logic [31:0] ack_number;
      logic        syn_flag;
      logic        rst_flag;
      logic        fin_flag;
      logic [15:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [5:0]  slot;
      logic [6:0]  active_count;
      logic [15:0] client_port_out;
      logic [15:0] server_port_out;
      logic [31:0] client_seq_out;
      logic [31:0] client_ack_out;
      logic [31:0] server_seq_out;
      logic [31:0] server_ack_out;
   } rsp_type;

   typedef struct packed {
      logic [15:0] cport;
      logic [15:0] sport;
      logic [31:0] cseq;
      logic [31:0] cack;
      logic [31:0] sseq;
      logic [31:0] sack;
   } entry_type;

   typedef struct packed {
      logic [1:0] op;
      entry_type  data;
   } cell_cmd_type;

endpackage

// ----- rtl/tstt_cell.sv -----
module tstt_cell #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             capture,
   input  logic [15:0]                      src_port,
   input  logic [15:0]                      dst_port,
   input  logic [$clog2(TABLE_DEPTH)-1:0]   win_rank,
   input  logic [$clog2(TABLE_DEPTH)-1:0]   cmd_rank,
   input  tstt_pkg::cell_cmd_type           cmd,
   input  logic                             free_before_in,
   output logic                             free_before_out,
   output logic                             match,
   output logic [$clog2(TABLE_DEPTH)-1:0]   rank,
   output logic                             hit,
   output logic                             first_free,
   output tstt_pkg::entry_type              entry
);
   import tstt_pkg::*;

   localparam int RW = $clog2(TABLE_DEPTH);

   logic          valid_ff;
   logic [RW-1:0] rank_ff;
   entry_type     data_ff;
   logic          sel_ff;
   logic          new_ff;

   assign match = valid_ff
      && (data_ff.cport == src_port || data_ff.sport == src_port)
      && (data_ff.cport == dst_port || data_ff.sport == dst_port);
   assign hit             = match && rank_ff == win_rank;
   assign first_free      = !valid_ff && !free_before_in;
   assign free_before_out = free_before_in || !valid_ff;
   assign rank            = rank_ff;
   assign entry           = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
         new_ff   <= 1'b0;
      end else begin
         if (capture) begin
            sel_ff <= hit;
            new_ff <= first_free;
         end
         case (cmd.op)
            OP_REMOVE: begin
               if (sel_ff) begin
                  valid_ff <= 1'b0;
               end else if (valid_ff && rank_ff > cmd_rank) begin
                  rank_ff <= rank_ff - 1'b1;
               end
            end
            OP_UPDATE: begin
               if (sel_ff) begin
                  data_ff <= cmd.data;
               end
            end
            OP_CREATE: begin
               if (new_ff) begin
                  valid_ff <= 1'b1;
                  rank_ff  <= cmd_rank;
                  data_ff  <= cmd.data;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ----- rtl/tcp_session_tracking_table_unit.sv -----
// Channel   Handshake           Payload
// request   start / busy        req_data (req_type)
// response  rsp_valid strobe    rsp_data (rsp_type)
// Each item has a match phase, to match all cells and pick the oldest hit
// and the lowest free slot, then an update phase, to update that cell and
// issue the response. busy is high only in the match cycle; the strobe
// follows the update phase, and the next start may coincide with it.
// Synchronous reset empties the table; the receiver cannot stall.
module tcp_session_tracking_table_unit #(
   parameter int TABLE_DEPTH = tstt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tstt_pkg::req_type req_data,
   output logic              rsp_valid,
   output tstt_pkg::rsp_type rsp_data
);
   import tstt_pkg::*;

   `include "tcp_session_tracking_table_unit_defines.svh"

   localparam int RW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   req_type       req_ff;
   logic          p1_ff;
   logic          p2_ff;
   logic [CW-1:0] live_ff;
   logic [CW-1:0] live_in;
   logic          found_ff;
   logic          free_ok_ff;
   logic [RW-1:0] win_rank_ff;
   logic [RW-1:0] hit_slot_ff;
   logic [RW-1:0] free_slot_ff;
   entry_type     hit_data_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;

   logic [TABLE_DEPTH-1:0] match_v;
   logic [TABLE_DEPTH-1:0] hit_v;
   logic [TABLE_DEPTH-1:0] free_v;
   logic [TABLE_DEPTH:0]   chain;
   logic [RW-1:0]          rank_a [TABLE_DEPTH];
   entry_type              entry_a [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] rank_hot;
   logic [RW-1:0]          win_rank;
   logic                   found;
   logic                   free_ok;
   logic [RW-1:0]          hit_slot;
   logic [RW-1:0]          free_slot;
   entry_type              hit_data;
   cell_cmd_type           cmd;
   logic [RW-1:0]          cmd_rank;
   entry_type              upd;
   logic [31:0]            len32;
   logic [31:0]            sseq_sum;

   assign chain[0] = 1'b0;

   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         tstt_cell #(.TABLE_DEPTH(TABLE_DEPTH)) u_cell (
            .clock           (clock),
            .reset           (reset),
            .capture         (p1_ff),
            .src_port        (req_ff.src_port),
            .dst_port        (req_ff.dst_port),
            .win_rank        (win_rank),
            .cmd_rank        (cmd_rank),
            .cmd             (cmd),
            .free_before_in  (chain[g]),
            .free_before_out (chain[g+1]),
            .match           (match_v[g]),
            .rank            (rank_a[g]),
            .hit             (hit_v[g]),
            .first_free      (free_v[g]),
            .entry           (entry_a[g])
         );
      end
   endgenerate

   always_comb begin
      rank_hot  = '0;
      win_rank  = '0;
      hit_slot  = '0;
      free_slot = '0;
      hit_data  = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (match_v[i]) begin
            rank_hot[rank_a[i]] = 1'b1;
         end
      end
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (rank_hot[i]) begin
            win_rank = RW'(i);
         end
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (hit_v[i]) begin
            hit_slot = hit_slot | RW'(i);
            hit_data = hit_data | entry_a[i];
         end
         if (free_v[i]) begin
            free_slot = free_slot | RW'(i);
         end
      end
   end

   assign found   = |match_v;
   assign free_ok = chain[TABLE_DEPTH];

   assign len32    = {16'd0, req_ff.payload_length};
   assign sseq_sum = hit_data_ff.sseq + len32;

   always_comb begin
      upd      = hit_data_ff;
      cmd.op   = OP_NONE;
      cmd.data = hit_data_ff;
      cmd_rank = win_rank_ff;
      live_in  = live_ff;
      rsp_in   = '0;
      rsp_in.active_count = 7'(live_ff);
      if (found_ff) begin
         if (req_ff.rst_flag || req_ff.fin_flag) begin
            cmd.op  = OP_REMOVE;
            live_in = live_ff - 1'b1;
            rsp_in.action = ACT_REMOVED;
         end else begin
            if (hit_data_ff.sport == req_ff.src_port) begin
               upd.cack = hit_data_ff.cack + len32;
               upd.sseq = sseq_sum;
               if (sseq_sum == 32'd0) begin
                  upd.sseq = req_ff.seq_number;
                  upd.cack = req_ff.seq_number + 32'd1;
               end
            end else begin
               upd.cseq = hit_data_ff.cseq + len32;
               upd.sack = hit_data_ff.sack + len32;
            end
            cmd.op   = OP_UPDATE;
            cmd.data = upd;
            rsp_in.action = ACT_UPDATED;
         end
         rsp_in.slot            = 6'(hit_slot_ff);
         rsp_in.client_port_out = cmd.data.cport;
         rsp_in.server_port_out = cmd.data.sport;
         rsp_in.client_seq_out  = cmd.data.cseq;
         rsp_in.client_ack_out  = cmd.data.cack;
         rsp_in.server_seq_out  = cmd.data.sseq;
         rsp_in.server_ack_out  = cmd.data.sack;
      end else if (!req_ff.syn_flag) begin
         rsp_in.action = ACT_IGNORED;
      end else if (live_ff == CW'(TABLE_DEPTH) || !free_ok_ff) begin
         rsp_in.action = ACT_DROPPED;
      end else begin
         cmd.op         = OP_CREATE;
         cmd.data.cport = req_ff.src_port;
         cmd.data.sport = req_ff.dst_port;
         cmd.data.cseq  = req_ff.seq_number;
         cmd.data.cack  = req_ff.ack_number;
         cmd.data.sseq  = 32'd0;
         cmd.data.sack  = req_ff.seq_number + 32'd1;
         cmd_rank       = RW'(live_ff);
         live_in        = live_ff + 1'b1;
         rsp_in.action          = ACT_CREATED;
         rsp_in.slot            = 6'(free_slot_ff);
         rsp_in.client_port_out = cmd.data.cport;
         rsp_in.server_port_out = cmd.data.sport;
         rsp_in.client_seq_out  = cmd.data.cseq;
         rsp_in.client_ack_out  = cmd.data.cack;
         rsp_in.server_seq_out  = cmd.data.sseq;
         rsp_in.server_ack_out  = cmd.data.sack;
      end
      rsp_in.active_count = 7'(live_in);
      if (!p2_ff) begin
         cmd.op = OP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_ff        <= start && !p1_ff;
         p2_ff        <= p1_ff;
         rsp_valid_ff <= p2_ff;
         if (p2_ff) begin
            live_ff <= live_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !p1_ff) begin
         req_ff <= req_data;
      end
      if (p1_ff) begin
         found_ff     <= found;
         free_ok_ff   <= free_ok;
         win_rank_ff  <= win_rank;
         hit_slot_ff  <= hit_slot;
         free_slot_ff <= free_slot;
         hit_data_ff  <= hit_data;
      end
      if (p2_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = p1_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TSTT_ASSERT_IMPL(a_phase_excl, p1_ff, !p2_ff, "match and update phases overlap")
   `TSTT_ASSERT_NEXT(a_p1_to_p2, p1_ff, p2_ff, "update phase missing after match")
   `TSTT_ASSERT_NEXT(a_rsp_after_p2, p2_ff, rsp_valid, "response strobe missing")
   `TSTT_ASSERT_IMPL(a_live_bound, 1'b1, live_ff <= CW'(TABLE_DEPTH), "live count overflow")

endmodule
